### design/mscc_pkg.sv
// Shared widths, register indexes and reset values for the marching squares classifier.
package mscc_pkg;

   // Field widths of the sample and cell channels.
   localparam int COLOR_W     = 8;
   localparam int CASE_W      = 4;
   localparam int CELL_W      = 9;

   // Configuration register widths and port widths.
   localparam int THRESH_W    = 8;
   localparam int GRIDCOL_W   = 10;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 10;
   localparam int SUM_W       = 10;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLUMNS = 4'd1;

   // Register reset values.
   localparam logic [THRESH_W-1:0]  THRESHOLD_RESET    = 8'd200;
   localparam logic [GRIDCOL_W-1:0] GRID_COLUMNS_RESET = 10'd257;

   // Smallest row length that the counters honour.
   localparam int MIN_COLUMNS = 2;

endpackage

### design/mscc_if.sv
// Channel interfaces for samples, cells and configuration writes.
interface mscc_req_if;
   logic                          valid;
   logic                          ready;
   logic [mscc_pkg::COLOR_W-1:0]  red;
   logic [mscc_pkg::COLOR_W-1:0]  green;
   logic [mscc_pkg::COLOR_W-1:0]  blue;
   logic                          frame_start;

   modport source (output valid, output red, output green, output blue,
                   output frame_start, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input frame_start, output ready);
endinterface

interface mscc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mscc_pkg::CASE_W-1:0]   case_index;
   logic [mscc_pkg::CELL_W-1:0]   cell_row;
   logic [mscc_pkg::CELL_W-1:0]   cell_col;

   modport source (output valid, output case_index, output cell_row,
                   output cell_col, input ready);
   modport sink   (input valid, input case_index, input cell_row,
                   input cell_col, output ready);
endinterface

interface mscc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mscc_pkg::CSR_INDEX_W-1:0]  index;
   logic [mscc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### design/mscc_line_buffer.sv
// One-bit line buffer holding the previous grid row, with registered read and bypass.
module mscc_line_buffer #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   output logic              rd_data
);

   logic mem [DEPTH];
   logic mem_rd_ff;
   logic bypass_ff;
   logic bypass_bit_ff;

   // Storage write, never cleared; the user must write every entry before it is used (not enforced).
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read. A write to the same entry at the same edge is taken from the bypass.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff     <= mem[rd_addr];
         bypass_ff     <= wr_en && (wr_addr == rd_addr);
         bypass_bit_ff <= wr_data;
      end
   end

   assign rd_data = bypass_ff ? bypass_bit_ff : mem_rd_ff;

endmodule

### design/mscc_classify.sv
// Brightness threshold of one sample and assembly of the four-corner case code.
module mscc_classify (
   input  logic [mscc_pkg::COLOR_W-1:0]  red,
   input  logic [mscc_pkg::COLOR_W-1:0]  green,
   input  logic [mscc_pkg::COLOR_W-1:0]  blue,
   input  logic [mscc_pkg::THRESH_W-1:0] threshold,
   input  logic                          upper_left_bit,
   input  logic                          above_bit,
   input  logic                          left_bit,
   output logic                          sample_bit,
   output logic [mscc_pkg::CASE_W-1:0]   case_index
);

   logic [mscc_pkg::SUM_W-1:0] sum;
   logic [mscc_pkg::SUM_W-1:0] limit;

   // The truncated average is at most t exactly when the sum is at most 3t + 2.
   assign sum   = mscc_pkg::SUM_W'(red) + mscc_pkg::SUM_W'(green) + mscc_pkg::SUM_W'(blue);
   assign limit = mscc_pkg::SUM_W'(threshold) * mscc_pkg::SUM_W'(3) + mscc_pkg::SUM_W'(2);
   assign sample_bit = (sum <= limit);

   // Corners from bit 3 down: top-left, top-right, bottom-right, bottom-left.
   assign case_index = {upper_left_bit, above_bit, sample_bit, left_bit};

endmodule

### design/marching_squares_cell_classifier.sv
// A cell is registered in the sample stage and then in the output register before it leaves on rsp_ch.
// Throughput: one sample per cycle while rsp_ch is not stalled; the line buffer takes one read and one write a cycle.
// A stalled output register holds the pipeline until the cell is taken.
// Reset clears the counters, neighbour bits and valid flags, and sets threshold to 200
// and grid_columns to 257. The line buffer is not cleared; the user must write each entry before use (not enforced).
module marching_squares_cell_classifier #(
   parameter int MAX_COLUMNS = 512,
   parameter int MAX_ROWS    = 512
) (
   input  logic           clock,
   input  logic           reset,
   mscc_req_if.sink       req_ch,
   mscc_rsp_if.source     rsp_ch,
   mscc_csr_if.sink       csr_ch
);

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int CMP_W = (COL_W + 1 > mscc_pkg::GRIDCOL_W) ? COL_W + 1 : mscc_pkg::GRIDCOL_W;

   // Configuration registers.
   logic [mscc_pkg::THRESH_W-1:0]  threshold_ff;
   logic [mscc_pkg::GRIDCOL_W-1:0] grid_columns_ff;

   // Position counters and neighbour bits.
   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic             left_bit_ff;
   logic             upper_left_bit_ff;

   // Sample stage.
   logic                         s1_valid_ff;
   logic [mscc_pkg::COLOR_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [COL_W-1:0]             s1_col_ff;
   logic [ROW_W-1:0]             s1_row_ff;

   // Output register.
   logic                          out_valid_ff;
   logic [mscc_pkg::CASE_W-1:0]   out_case_ff;
   logic [mscc_pkg::CELL_W-1:0]   out_row_ff, out_col_ff;
   logic [mscc_pkg::CELL_W-1:0]   out_row_in, out_col_in;

   logic             accept;
   logic             produce;
   logic             advance;
   logic [COL_W-1:0] col_cur;
   logic [ROW_W-1:0] row_cur;
   logic [CMP_W-1:0] grid_ext;
   logic [CMP_W-1:0] cols_eff;
   logic [CMP_W-1:0] col_plus;
   logic [ROW_W:0]   row_plus;
   logic             above_bit;
   logic             sample_bit;
   logic [mscc_pkg::CASE_W-1:0] case_index;
   logic [ROW_W-1:0] row_m1;
   logic [COL_W-1:0] col_m1;
   logic [ROW_W+mscc_pkg::CELL_W-1:0] row_wide;
   logic [COL_W+mscc_pkg::CELL_W-1:0] col_wide;

   // Handshake: the sample stage empties into the output register, or moves on alone when
   // the sample yields no cell.
   assign produce = (s1_row_ff != '0) && (s1_col_ff != '0);
   assign advance = s1_valid_ff && (!produce || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Configuration writes; indexes outside the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= mscc_pkg::THRESHOLD_RESET;
         grid_columns_ff <= mscc_pkg::GRID_COLUMNS_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            mscc_pkg::CSR_THRESHOLD:    threshold_ff    <= csr_ch.data[mscc_pkg::THRESH_W-1:0];
            mscc_pkg::CSR_GRID_COLUMNS: grid_columns_ff <= csr_ch.data[mscc_pkg::GRIDCOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Position of the incoming sample and the counters after it.
   assign col_cur  = req_ch.frame_start ? '0 : column_count_ff;
   assign row_cur  = req_ch.frame_start ? '0 : row_count_ff;
   assign grid_ext = CMP_W'(grid_columns_ff);
   assign col_plus = CMP_W'(col_cur) + CMP_W'(1);
   assign row_plus = (ROW_W+1)'(row_cur) + (ROW_W+1)'(1);

   always_comb begin
      if (grid_ext < CMP_W'(mscc_pkg::MIN_COLUMNS)) begin
         cols_eff = CMP_W'(mscc_pkg::MIN_COLUMNS);
      end else if (grid_ext > CMP_W'(MAX_COLUMNS)) begin
         cols_eff = CMP_W'(MAX_COLUMNS);
      end else begin
         cols_eff = grid_ext;
      end
      if (col_plus >= cols_eff) begin
         column_count_in = '0;
         row_count_in    = (row_plus >= (ROW_W+1)'(MAX_ROWS)) ? '0 : row_plus[ROW_W-1:0];
      end else begin
         column_count_in = col_plus[COL_W-1:0];
         row_count_in    = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (accept) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // Sample stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_red_ff   <= req_ch.red;
         s1_green_ff <= req_ch.green;
         s1_blue_ff  <= req_ch.blue;
         s1_col_ff   <= col_cur;
         s1_row_ff   <= row_cur;
      end
   end

   // Previous-row bits, read as the sample is taken and written as it leaves the stage.
   mscc_line_buffer #(
      .DEPTH  (MAX_COLUMNS),
      .ADDR_W (COL_W)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .wr_en   (advance),
      .wr_addr (s1_col_ff),
      .wr_data (sample_bit),
      .rd_data (above_bit)
   );

   mscc_classify u_classify (
      .red            (s1_red_ff),
      .green          (s1_green_ff),
      .blue           (s1_blue_ff),
      .threshold      (threshold_ff),
      .upper_left_bit (upper_left_bit_ff),
      .above_bit      (above_bit),
      .left_bit       (left_bit_ff),
      .sample_bit     (sample_bit),
      .case_index     (case_index)
   );

   // Neighbour bits follow the sample that leaves the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_bit_ff       <= 1'b0;
         upper_left_bit_ff <= 1'b0;
      end else if (advance) begin
         left_bit_ff       <= sample_bit;
         upper_left_bit_ff <= above_bit;
      end
   end

   // Cell position is one less than the sample position, kept to the port width.
   assign row_m1     = s1_row_ff - ROW_W'(1);
   assign col_m1     = s1_col_ff - COL_W'(1);
   assign row_wide   = (ROW_W+mscc_pkg::CELL_W)'(row_m1);
   assign col_wide   = (COL_W+mscc_pkg::CELL_W)'(col_m1);
   assign out_row_in = row_wide[mscc_pkg::CELL_W-1:0];
   assign out_col_in = col_wide[mscc_pkg::CELL_W-1:0];

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         out_case_ff <= case_index;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.case_index = out_case_ff;
   assign rsp_ch.cell_row   = out_row_ff;
   assign rsp_ch.cell_col   = out_col_ff;

   // Samples are refused only while both stages are full and the cell is not taken.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && out_valid_ff && !rsp_ch.ready))
      else $error("sample refused while the pipeline could move");

   // An accepted sample occupies the sample stage in the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted sample lost before the sample stage");

   // A new cell only appears from a sample that was in the stage.
   a_cell_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff))
      else $error("cell presented without a sample behind it");

endmodule

### tb/tb.sv
// Self-checking testbench for the marching squares cell classifier, with a scoreboard class.
`timescale 1ns / 100ps

module tb;

   localparam int GRID_MAX_COLS   = 512;
   localparam int GRID_MAX_ROWS   = 512;
   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 6;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int TIMEOUT_NS      = 30_000_000;

   typedef struct packed {
      logic [mscc_pkg::COLOR_W-1:0] red;
      logic [mscc_pkg::COLOR_W-1:0] green;
      logic [mscc_pkg::COLOR_W-1:0] blue;
      logic                         frame_start;
   } sample_type;

   typedef struct packed {
      logic [mscc_pkg::CASE_W-1:0] case_index;
      logic [mscc_pkg::CELL_W-1:0] cell_row;
      logic [mscc_pkg::CELL_W-1:0] cell_col;
   } cell_type;

   // Tracks the grid position, the line buffer and the registers, and holds the cells
   // that are still to come out of the block.
   class cell_checker;
      logic [mscc_pkg::THRESH_W-1:0]  threshold;
      logic [mscc_pkg::GRIDCOL_W-1:0] grid_columns;
      bit                             line_bits [GRID_MAX_COLS];
      bit                             left_bit;
      bit                             upper_left_bit;
      int                             column_count;
      int                             row_count;
      cell_type                       expected_cells [$];
      int                             errors;

      function new();
         threshold      = mscc_pkg::THRESHOLD_RESET;
         grid_columns   = mscc_pkg::GRID_COLUMNS_RESET;
         left_bit       = 1'b0;
         upper_left_bit = 1'b0;
         column_count   = 0;
         row_count      = 0;
         errors         = 0;
         foreach (line_bits[i]) line_bits[i] = 1'b0;
      endfunction

      // Row length as the counters honour it.
      function int row_length();
         if (grid_columns < mscc_pkg::MIN_COLUMNS) return mscc_pkg::MIN_COLUMNS;
         if (grid_columns > GRID_MAX_COLS) return GRID_MAX_COLS;
         return int'(grid_columns);
      endfunction

      function void write_register(input logic [mscc_pkg::CSR_INDEX_W-1:0] index,
                                   input logic [mscc_pkg::CSR_DATA_W-1:0]  data);
         case (index)
            mscc_pkg::CSR_THRESHOLD: begin
               threshold = data[mscc_pkg::THRESH_W-1:0];
            end
            mscc_pkg::CSR_GRID_COLUMNS: begin
               grid_columns = data[mscc_pkg::GRIDCOL_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Classifies one accepted sample and queues the cell whose lower-right corner it is.
      function void classify_sample(input sample_type s);
         int       brightness;
         int       col;
         int       row;
         bit       marked;
         bit       above;
         cell_type next_cell;
         if (s.frame_start) begin
            column_count = 0;
            row_count    = 0;
         end
         brightness = (int'(s.red) + int'(s.green) + int'(s.blue)) / 3;
         marked     = (brightness <= int'(threshold));
         col        = column_count % GRID_MAX_COLS;
         row        = row_count;
         above      = line_bits[col];
         if (row >= 1 && col >= 1) begin
            next_cell.case_index = {upper_left_bit, above, marked, left_bit};
            next_cell.cell_row   = mscc_pkg::CELL_W'(row - 1);
            next_cell.cell_col   = mscc_pkg::CELL_W'(col - 1);
            expected_cells.push_back(next_cell);
         end
         upper_left_bit = above;
         line_bits[col] = marked;
         left_bit       = marked;
         // A column at or past the row length ends the row.
         if (col + 1 >= row_length()) begin
            column_count = 0;
            row_count    = (row + 1 >= GRID_MAX_ROWS) ? 0 : row + 1;
         end else begin
            column_count = col + 1;
         end
      endfunction

      task report(input string what);
         $display("MISMATCH at %0t ns: %s", $time, what);
         errors++;
      endtask

      task check_cell(input cell_type got);
         cell_type want;
         if (expected_cells.size() == 0) begin
            report($sformatf("unexpected cell: case %0d row %0d col %0d",
                             got.case_index, got.cell_row, got.cell_col));
            return;
         end
         want = expected_cells.pop_front();
         if (got.case_index !== want.case_index)
            report($sformatf("case_index %0d, wanted %0d (cell row %0d col %0d)",
                             got.case_index, want.case_index, want.cell_row, want.cell_col));
         if (got.cell_row !== want.cell_row)
            report($sformatf("cell_row %0d, wanted %0d", got.cell_row, want.cell_row));
         if (got.cell_col !== want.cell_col)
            report($sformatf("cell_col %0d, wanted %0d", got.cell_col, want.cell_col));
      endtask

      function int pending();
         return expected_cells.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   mscc_req_if req_ch ();
   mscc_rsp_if rsp_ch ();
   mscc_csr_if csr_ch ();

   marching_squares_cell_classifier #(
      .MAX_COLUMNS (GRID_MAX_COLS),
      .MAX_ROWS    (GRID_MAX_ROWS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cell_checker cells = new();

   bit hold_off_request;
   int sender_steady;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Every cell transaction is checked against the oldest expected cell.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         cells.check_cell({rsp_ch.case_index, rsp_ch.cell_row, rsp_ch.cell_col});
   end

   // Receiver: mostly ready, with short and occasional long stalls, steady stretches,
   // and one long hold-off on request so that the block backs up.
   initial begin : result_sink
      int hold;
      int steady;
      int pick;
      hold   = 0;
      steady = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold   = HOLD_OFF_CYCLES;
            steady = 0;
         end
         if (steady > 0) begin
            steady--;
            rsp_ch.ready = 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_ch.ready = 1'b0;
         end else begin
            pick = $urandom_range(0, 999);
            if (pick < 5) begin
               steady = $urandom_range(30, 150);
               rsp_ch.ready = 1'b1;
            end else if (pick < 10) begin
               hold = $urandom_range(20, 60);
               rsp_ch.ready = 1'b0;
            end else if (pick < 300) begin
               hold = $urandom_range(0, 3);
               rsp_ch.ready = 1'b0;
            end else begin
               rsp_ch.ready = 1'b1;
            end
         end
         @(negedge clock);
      end
   end

   // Idle cycles before the next sample: mostly none, some short, a few long.
   function automatic int next_gap();
      int pick;
      if (sender_steady > 0) begin
         sender_steady--;
         return 0;
      end
      pick = $urandom_range(0, 999);
      if (pick < 8) begin
         sender_steady = $urandom_range(20, 120);
         return 0;
      end
      if (pick < 600) return 0;
      if (pick < 900) return $urandom_range(1, 3);
      if (pick < 985) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Offers one sample and waits for its transaction. Starts and ends at a falling edge.
   task automatic send_sample(input sample_type s);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.red         = s.red;
      req_ch.green       = s.green;
      req_ch.blue        = s.blue;
      req_ch.frame_start = s.frame_start;
      req_ch.valid       = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      cells.classify_sample(s);
      @(negedge clock);
   endtask

   // One register write transaction. Starts and ends at a falling edge.
   task automatic write_csr(input logic [mscc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [mscc_pkg::CSR_DATA_W-1:0]  data);
      csr_ch.index = index;
      csr_ch.data  = data;
      csr_ch.valid = 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      cells.write_register(index, data);
      @(negedge clock);
      csr_ch.valid = 1'b0;
      @(negedge clock);
   endtask

   // Waits for every expected cell, up to the drain limit, then lets the pipeline settle.
   task automatic wait_idle();
      int waited;
      waited = 0;
      while (cells.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random sample: fully random, clustered around the threshold, or saturated colours.
   function automatic sample_type random_sample(input int level, input int restart_odds);
      sample_type                   s;
      int                           mode;
      int                           k;
      logic [mscc_pkg::COLOR_W-1:0] comp [3];
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
         case (mode)
            1: begin
               k = level + int'($urandom_range(0, 4)) - 2;
               comp[i] = (k < 0) ? 8'h00 : ((k > 255) ? 8'hFF : mscc_pkg::COLOR_W'(k));
            end
            2: begin
               comp[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: begin
               comp[i] = mscc_pkg::COLOR_W'($urandom_range(0, 255));
            end
         endcase
      end
      s.red         = comp[0];
      s.green       = comp[1];
      s.blue        = comp[2];
      s.frame_start = (restart_odds > 0) && ($urandom_range(1, restart_odds) == 1);
      return s;
   endfunction

   // One setting of the registers followed by a run of random samples. A longer row
   // starts a new grid, so that no line buffer entry is read before it is written.
   task automatic run_phase(input int level, input int columns, input int count,
                            input int restart_odds, input bit squeeze);
      int         old_length;
      sample_type s;
      wait_idle();
      old_length = cells.row_length();
      write_csr(mscc_pkg::CSR_THRESHOLD, mscc_pkg::CSR_DATA_W'(level));
      write_csr(mscc_pkg::CSR_GRID_COLUMNS, mscc_pkg::CSR_DATA_W'(columns));
      for (int n = 0; n < count; n++) begin
         s = random_sample(level, restart_odds);
         if (n == 0 && cells.row_length() > old_length) s.frame_start = 1'b1;
         if (squeeze && n == 20) hold_off_request = 1'b1;
         send_sample(s);
      end
      req_ch.valid = 1'b0;
   endtask

   // Main sequence: reset, a directed grid, then phases over several settings.
   initial begin : stimulus
      // Three-column grid at threshold 100: colour extremes, averages on either side of
      // the threshold, and a new grid started in the middle of a row.
      sample_type opening [20] = '{
         '{8'd0,   8'd0,   8'd0,   1'b1}, '{8'd255, 8'd255, 8'd255, 1'b0},
         '{8'd100, 8'd100, 8'd100, 1'b0}, '{8'd101, 8'd101, 8'd101, 1'b0},
         '{8'd100, 8'd100, 8'd102, 1'b0}, '{8'd0,   8'd0,   8'd255, 1'b0},
         '{8'd255, 8'd255, 8'd0,   1'b0}, '{8'd255, 8'd0,   8'd45,  1'b0},
         '{8'd0,   8'd0,   8'd0,   1'b0}, '{8'd255, 8'd255, 8'd255, 1'b0},
         '{8'd255, 8'd255, 8'd255, 1'b0}, '{8'd101, 8'd101, 8'd102, 1'b0},
         '{8'd0,   8'd0,   8'd0,   1'b0}, '{8'd0,   8'd0,   8'd0,   1'b0},
         '{8'd0,   8'd0,   8'd0,   1'b1}, '{8'd255, 8'd255, 8'd255, 1'b0},
         '{8'd0,   8'd255, 8'd255, 1'b0}, '{8'd0,   8'd0,   8'd0,   1'b0},
         '{8'd77,  8'd77,  8'd77,  1'b0}, '{8'd200, 8'd200, 8'd200, 1'b0}
      };
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.red         = '0;
      req_ch.green       = '0;
      req_ch.blue        = '0;
      req_ch.frame_start = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;
      hold_off_request   = 1'b0;
      sender_steady      = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      write_csr(mscc_pkg::CSR_THRESHOLD, mscc_pkg::CSR_DATA_W'(100));
      write_csr(mscc_pkg::CSR_GRID_COLUMNS, mscc_pkg::CSR_DATA_W'(3));
      foreach (opening[i]) send_sample(opening[i]);
      req_ch.valid = 1'b0;

      // Reset values written back, long enough to reach the second row, then the
      // threshold extremes and short rows.
      run_phase(int'(mscc_pkg::THRESHOLD_RESET), int'(mscc_pkg::GRID_COLUMNS_RESET),
                280, 0, 1'b0);
      run_phase(0, 4, 60, 50, 1'b1);
      run_phase(255, 1, 20, 0, 1'b0);
      run_phase($urandom_range(0, 255), 0, 20, 0, 1'b0);
      // Shrinking the row after a partial row pushes the column past the row end.
      run_phase($urandom_range(0, 255), 7, 30, 40, 1'b0);
      run_phase($urandom_range(0, 255), 5, 20, 0, 1'b0);
      // Longest row, clamped from above, and a setting that clamps to the same length.
      run_phase(128, 1023, 20, 0, 1'b0);
      run_phase($urandom_range(0, 255), 513, 10, 0, 1'b0);
      // Shortest row, entered with the column far past its end.
      run_phase($urandom_range(0, 255), 2, 20, 0, 1'b0);
      run_phase($urandom_range(0, 255), 6, 30, 30, 1'b0);

      wait_idle();
      if (cells.pending() != 0)
         cells.report($sformatf("%0d expected cells never came out", cells.pending()));
      if (cells.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
design/mscc_pkg.sv
design/mscc_if.sv
design/mscc_line_buffer.sv
design/mscc_classify.sv
design/marching_squares_cell_classifier.sv
tb/tb.sv
